// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication-style check on the block clock.
`define UTF8E_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds on the block clock.
`define UTF8E_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/utf8e_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8e_pkg
// Shared types and constants of the UTF-16 to UTF-8 encoder.
// ----------------------------------------------------------------------------
package utf8e_pkg;

  localparam int unsigned UnitW    = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned JobBytes = 6;
  localparam int unsigned CntW     = $clog2(JobBytes + 1);
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [5:0] HiSurrTag = 6'b110110;
  localparam logic [5:0] LoSurrTag = 6'b110111;

  // Byte list for one input item, entry 0 goes out first.
  typedef struct packed {
    logic [CntW-1:0]                count;
    logic [JobBytes-1:0][ByteW-1:0] bytes;
  } job_t;

endpackage

// ===== rtl/utf16_to_utf8_encoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_top
// UTF-16 code units in, UTF-8 bytes out, surrogate pairs joined.
// ----------------------------------------------------------------------------
// One code unit per input beat, one byte per output beat. A unit yields 1 to 3
// bytes for a plain unit, 4 for a surrogate pair, up to 6 when a held high
// surrogate is flushed ahead of the next unit, and none for a high surrogate
// that is held. The byte-wide output register sets the rate; a two-entry queue
// of byte lists lets the input side take new units while earlier bytes drain.
// With the queue empty, a unit's byte list is registered in a queue slot and
// its first byte is then registered in the output byte register.
module utf16_to_utf8_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_unit_i,
  input  logic        end_of_string_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  byte_value_o,
  output logic        last_of_run_o
);

  `include "assert_macros.svh"

  logic            push_valid, push_ready;
  utf8e_pkg::job_t push_job;
  logic            pop_valid, pop_ready;
  utf8e_pkg::job_t pop_job;
  logic            pend;
  logic            busy;

  utf8e_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .code_unit_i    (code_unit_i),
    .end_of_string_i(end_of_string_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_job_o     (push_job),
    .pend_o         (pend)
  );

  utf8e_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_job_i  (push_job),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_job_o   (pop_job)
  );

  utf8e_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (pop_valid),
    .job_ready_o  (pop_ready),
    .job_i        (pop_job),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .byte_value_o (byte_value_o),
    .last_of_run_o(last_of_run_o),
    .busy_o       (busy)
  );

  `UTF8E_ASSERT(a_eos_flushes, in_valid_i && in_ready_o && end_of_string_i |=> !pend, "surrogate held past end of string")
  `UTF8E_ASSERT(a_push_count, push_valid && push_ready |-> (push_job.count != 3'd0) && (push_job.count <= 3'd6), "bad byte count pushed")
  `UTF8E_ASSERT(a_busy_has_job, busy |-> pop_valid, "byte list dropped mid-run")

endmodule

// ===== rtl/utf8e_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8e_front
// Accepts code units, pairs surrogates and builds the byte list of each beat.
// ----------------------------------------------------------------------------
module utf8e_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [utf8e_pkg::UnitW-1:0]       code_unit_i,
  input  logic                              end_of_string_i,
  output logic                              push_valid_o,
  input  logic                              push_ready_i,
  output utf8e_pkg::job_t                   push_job_o,
  output logic                              pend_o
);

  logic       pend_q, pend_d;
  logic [9:0] pend_bits_q, pend_bits_d;

  logic       accept;
  logic       is_hi, is_lo, pair;
  logic [4:0] plane;
  logic [2:0][utf8e_pkg::ByteW-1:0] ub;
  logic [2:0][utf8e_pkg::ByteW-1:0] pre;
  logic [utf8e_pkg::CntW-1:0]       ucnt;
  logic       hold;
  utf8e_pkg::job_t job;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_hi = (code_unit_i[15:10] == utf8e_pkg::HiSurrTag);
  assign is_lo = (code_unit_i[15:10] == utf8e_pkg::LoSurrTag);
  assign pair  = pend_q && is_lo;
  assign plane = {1'b0, pend_bits_q[9:6]} + 5'd1;

  always_comb begin
    ub   = '0;
    ucnt = '0;
    hold = 1'b0;
    if (code_unit_i[15:7] == '0) begin
      ub[0] = {1'b0, code_unit_i[6:0]};
      ucnt  = utf8e_pkg::CntW'(1);
    end else if (code_unit_i[15:11] == '0) begin
      ub[0] = {3'b110, code_unit_i[10:6]};
      ub[1] = {2'b10, code_unit_i[5:0]};
      ucnt  = utf8e_pkg::CntW'(2);
    end else if (is_hi && !end_of_string_i) begin
      hold = 1'b1;
    end else begin
      ub[0] = {4'hE, code_unit_i[15:12]};
      ub[1] = {2'b10, code_unit_i[11:6]};
      ub[2] = {2'b10, code_unit_i[5:0]};
      ucnt  = utf8e_pkg::CntW'(3);
    end
  end

  // Held high surrogate emitted alone.
  assign pre[0] = {4'hE, 4'hD};
  assign pre[1] = {4'b1010, pend_bits_q[9:6]};
  assign pre[2] = {2'b10, pend_bits_q[5:0]};

  always_comb begin
    job = '0;
    if (pair) begin
      job.count    = utf8e_pkg::CntW'(4);
      job.bytes[0] = {5'b11110, plane[4:2]};
      job.bytes[1] = {2'b10, plane[1:0], pend_bits_q[5:2]};
      job.bytes[2] = {2'b10, pend_bits_q[1:0], code_unit_i[9:6]};
      job.bytes[3] = {2'b10, code_unit_i[5:0]};
    end else if (pend_q) begin
      job.count    = ucnt + utf8e_pkg::CntW'(3);
      job.bytes[0] = pre[0];
      job.bytes[1] = pre[1];
      job.bytes[2] = pre[2];
      job.bytes[3] = ub[0];
      job.bytes[4] = ub[1];
      job.bytes[5] = ub[2];
    end else begin
      job.count    = ucnt;
      job.bytes[0] = ub[0];
      job.bytes[1] = ub[1];
      job.bytes[2] = ub[2];
    end
  end

  assign push_job_o   = job;
  assign push_valid_o = in_valid_i && (job.count != '0);

  always_comb begin
    pend_d      = pend_q;
    pend_bits_d = pend_bits_q;
    if (accept) begin
      pend_d      = hold && !pair;
      pend_bits_d = (hold && !pair) ? code_unit_i[9:0] : 10'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      pend_bits_q <= '0;
    end else begin
      pend_q      <= pend_d;
      pend_bits_q <= pend_bits_d;
    end
  end

  assign pend_o = pend_q;

endmodule

// ===== rtl/utf8e_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8e_queue
// Short register queue of byte lists between the front and back parts.
// ----------------------------------------------------------------------------
module utf8e_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  utf8e_pkg::job_t push_job_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output utf8e_pkg::job_t pop_job_o
);

  utf8e_pkg::job_t slot_q [utf8e_pkg::QDepth];

  logic [utf8e_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [utf8e_pkg::QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [utf8e_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic                        push, pop;

  assign push_ready_o = (cnt_q != utf8e_pkg::QCntW'(utf8e_pkg::QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = slot_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == utf8e_pkg::QPtrW'(utf8e_pkg::QDepth - 1)) ? '0
               : wr_ptr_q + utf8e_pkg::QPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == utf8e_pkg::QPtrW'(utf8e_pkg::QDepth - 1)) ? '0
               : rd_ptr_q + utf8e_pkg::QPtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + utf8e_pkg::QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - utf8e_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== rtl/utf8e_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8e_back
// Walks the head byte list and drives one UTF-8 byte per beat.
// ----------------------------------------------------------------------------
module utf8e_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  output logic                        job_ready_o,
  input  utf8e_pkg::job_t             job_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [utf8e_pkg::ByteW-1:0] byte_value_o,
  output logic                        last_of_run_o,
  output logic                        busy_o
);

  logic [utf8e_pkg::CntW-1:0]  idx_q, idx_d;
  logic                        vld_q, vld_d;
  logic [utf8e_pkg::ByteW-1:0] byte_q, byte_d;
  logic                        last_q, last_d;
  logic                        load, is_last;

  assign is_last = (idx_q == job_i.count - utf8e_pkg::CntW'(1));
  assign load    = job_valid_i && (!vld_q || out_ready_i);

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q && !out_ready_i;
    byte_d = byte_q;
    last_d = last_q;
    if (load) begin
      vld_d  = 1'b1;
      byte_d = job_i.bytes[idx_q];
      last_d = is_last;
      idx_d  = is_last ? '0 : idx_q + utf8e_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign job_ready_o   = load && is_last;
  assign out_valid_o   = vld_q;
  assign byte_value_o  = byte_q;
  assign last_of_run_o = last_q;
  assign busy_o        = (idx_q != '0);

endmodule
